### hw/rtl/triangle_tangent_generator_defines.svh
// Assertion macros for the triangle tangent generator checker.
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ttg_pkg.sv
// Shared types, sizes and helpers for the triangle tangent generator.
`timescale 1ns / 1ps
package ttg_pkg;

  localparam int FaceDepth = 2;
  localparam int FacePtrW  = $clog2(FaceDepth);
  localparam int FaceCntW  = $clog2(FaceDepth + 1);
  localparam int OutDepth  = 4;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int OutCntW   = $clog2(OutDepth + 1);

  // One completed face: scaled edges, scaled v deltas, and the three normals.
  typedef struct packed {
    logic [2:0][30:0]       e1;
    logic [2:0][30:0]       e2;
    logic [30:0]            d1;
    logic [30:0]            d2;
    logic [2:0][2:0][15:0]  nrm;   // [vertex][component]
  } face_t;

  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        degenerate;
    logic        last;
  } res_t;

  typedef struct packed {
    logic            start;
    logic [2:0][63:0] vec;
  } norm_req_t;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [2:0][15:0] res;
  } norm_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_TMUL, B_TSUB, B_TSTART, B_TWAIT, B_NSTART, B_NWAIT,
    B_DMUL, B_DACC, B_RMUL, B_RSUB, B_RSTART, B_RWAIT, B_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV, N_DONE
  } norm_state_e;

  // True when v, arithmetically shifted right by sh, fits in 31 bit signed.
  function automatic logic fits31(input logic [32:0] v, input logic [1:0] sh);
    logic [32:0] s;
    s = $signed(v) >>> sh;
    return (s[32:30] == 3'b000) || (s[32:30] == 3'b111);
  endfunction

endpackage

### hw/rtl/ttg_front.sv
// Front end: holds the first two vertices, forms scaled edges and queues faces.
`timescale 1ns / 1ps
module ttg_front import ttg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_v_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  output logic               face_valid_o,
  output face_t              face_o,
  input  logic               face_pop_i
);

  logic [1:0]             vif_q;
  logic [1:0][2:0][31:0]  hpos_q;
  logic [1:0][31:0]       htv_q;
  logic [1:0][2:0][15:0]  hnrm_q;

  face_t                  mem_q [FaceDepth];
  logic [FacePtrW-1:0]    wptr_q, rptr_q;
  logic [FaceCntW-1:0]    cnt_q;

  logic                   accept, face_done;
  logic [2:0][31:0]       pin;
  logic [2:0][32:0]       e1w, e2w;
  logic [32:0]            d1w, d2w;
  logic                   efit0, efit1, dfit0, dfit1;
  logic [1:0]             se, sd;
  logic [32:0]            sh_tmp;
  face_t                  face_w;

  assign full      = (cnt_q == FaceCntW'(FaceDepth));
  assign accept    = push && !full;
  assign face_done = accept && (vif_q == 2'd2);
  assign pin       = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1w[i] = 33'($signed(hpos_q[1][i])) - 33'($signed(hpos_q[0][i]));
      e2w[i] = 33'($signed(pin[i]))       - 33'($signed(hpos_q[0][i]));
    end
    d1w = 33'($signed(htv_q[1])) - 33'($signed(htv_q[0]));
    d2w = 33'($signed(tex_v_i))  - 33'($signed(htv_q[0]));
    efit0 = 1'b1;
    efit1 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      efit0 = efit0 && fits31(e1w[i], 2'd0) && fits31(e2w[i], 2'd0);
      efit1 = efit1 && fits31(e1w[i], 2'd1) && fits31(e2w[i], 2'd1);
    end
    dfit0 = fits31(d1w, 2'd0) && fits31(d2w, 2'd0);
    dfit1 = fits31(d1w, 2'd1) && fits31(d2w, 2'd1);
    se = efit0 ? 2'd0 : (efit1 ? 2'd1 : 2'd2);
    sd = dfit0 ? 2'd0 : (dfit1 ? 2'd1 : 2'd2);
    for (int i = 0; i < 3; i++) begin
      sh_tmp        = $signed(e1w[i]) >>> se;
      face_w.e1[i]  = sh_tmp[30:0];
      sh_tmp        = $signed(e2w[i]) >>> se;
      face_w.e2[i]  = sh_tmp[30:0];
    end
    sh_tmp    = $signed(d1w) >>> sd;
    face_w.d1 = sh_tmp[30:0];
    sh_tmp    = $signed(d2w) >>> sd;
    face_w.d2 = sh_tmp[30:0];
    face_w.nrm[0] = hnrm_q[0];
    face_w.nrm[1] = hnrm_q[1];
    face_w.nrm[2] = {norm_z_i, norm_y_i, norm_x_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vif_q  <= '0;
      hpos_q <= '0;
      htv_q  <= '0;
      hnrm_q <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        if (vif_q == 2'd2) begin
          vif_q <= '0;
        end else begin
          hpos_q[vif_q[0]] <= pin;
          htv_q[vif_q[0]]  <= tex_v_i;
          hnrm_q[vif_q[0]] <= {norm_z_i, norm_y_i, norm_x_i};
          vif_q            <= vif_q + 2'd1;
        end
      end
      if (face_done) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (face_pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + FaceCntW'(face_done) - FaceCntW'(face_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (face_done) begin
      mem_q[wptr_q] <= face_w;
    end
  end

  assign face_valid_o = (cnt_q != '0);
  assign face_o       = mem_q[rptr_q];

endmodule

### hw/rtl/ttg_norm.sv
// Shared normalizer: scale, sum of squares, bit-serial sqrt, restoring divide.
`timescale 1ns / 1ps
module ttg_norm import ttg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  norm_state_e       state_q, state_d;
  logic [2:0]        neg_q;
  logic [2:0][63:0]  m_q;
  logic [59:0]       sq_q;
  logic [63:0]       sum_q;
  logic [1:0]        cnt_q;
  logic [63:0]       v_q, res_q, bit_q;
  logic [31:0]       len_q;
  logic [1:0]        ci_q;
  logic [32:0]       rem_q;
  logic [15:0]       nlo_q, quo_q;
  logic [3:0]        step_q;
  logic              ok_q;
  logic [2:0][15:0]  out_q;

  logic [63:0]       orv, rb;
  logic              sq_ge;
  logic [29:0]       sq_src;
  logic [45:0]       num;
  logic [33:0]       r2;
  logic [32:0]       dvs;
  logic              qbit;
  logic [15:0]       qnext;

  always_comb begin
    orv    = m_q[0] | m_q[1] | m_q[2];
    rb     = res_q + bit_q;
    sq_ge  = (v_q >= rb);
    unique case (cnt_q)
      2'd0:    sq_src = m_q[0][29:0];
      2'd1:    sq_src = m_q[1][29:0];
      2'd2:    sq_src = m_q[2][29:0];
      default: sq_src = '0;
    endcase
    num   = {1'b0, m_q[ci_q][29:0], 15'd0} + 46'(len_q);
    dvs   = {len_q, 1'b0};
    r2    = {rem_q, nlo_q[15]};
    qbit  = (r2 >= {1'b0, dvs});
    qnext = {quo_q[14:0], qbit};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (req_i.start) state_d = N_SHIFT;
      N_SHIFT: begin
        if (orv == '0) begin
          state_d = N_DONE;
        end else if (orv[63:30] == '0 && orv[29]) begin
          state_d = N_SQ;
        end
      end
      N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
      N_SQRT:  if (bit_q[0]) state_d = N_DSET;
      N_DSET:  state_d = N_DIV;
      N_DIV: begin
        if (step_q == 4'd15) begin
          state_d = (ci_q == 2'd2) ? N_DONE : N_DSET;
        end
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= req_i.vec[i][63];
          m_q[i]   <= req_i.vec[i][63] ? (64'd0 - req_i.vec[i]) : req_i.vec[i];
        end
        cnt_q <= '0;
        sum_q <= '0;
        ci_q  <= '0;
      end
      N_SHIFT: begin
        if (orv == '0) begin
          ok_q  <= 1'b0;
          out_q <= '0;
        end else if (orv[63:30] != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!orv[29]) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
      end
      N_SQ: begin
        sq_q  <= sq_src * sq_src;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          v_q   <= sum_q + 64'(sq_q);
          res_q <= '0;
          bit_q <= 64'd1 << 62;
        end else if (cnt_q != 2'd0) begin
          sum_q <= sum_q + 64'(sq_q);
        end
      end
      N_SQRT: begin
        if (sq_ge) begin
          v_q   <= v_q - rb;
          res_q <= (res_q >> 1) + bit_q;
          len_q <= 32'((res_q >> 1) + bit_q);
        end else begin
          res_q <= res_q >> 1;
          len_q <= 32'(res_q >> 1);
        end
        bit_q <= bit_q >> 2;
      end
      N_DSET: begin
        rem_q  <= 33'(num[45:16]);
        nlo_q  <= num[15:0];
        quo_q  <= '0;
        step_q <= '0;
      end
      N_DIV: begin
        rem_q  <= qbit ? 33'(r2 - {1'b0, dvs}) : r2[32:0];
        nlo_q  <= nlo_q << 1;
        quo_q  <= qnext;
        step_q <= step_q + 4'd1;
        if (step_q == 4'd15) begin
          out_q[ci_q] <= neg_q[ci_q] ? (16'd0 - qnext) : qnext;
          ci_q        <= ci_q + 2'd1;
          ok_q        <= 1'b1;
        end
      end
      N_DONE: ;
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == N_DONE);
  assign rsp_o.ok   = ok_q;
  assign rsp_o.res  = out_q;

endmodule

### hw/rtl/ttg_back.sv
// Back end: face tangent, per-vertex Gram-Schmidt, and the result queue.
`timescale 1ns / 1ps
module ttg_back import ttg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               face_valid_i,
  input  face_t              face_i,
  output logic               face_pop_o,
  output norm_req_t          norm_req_o,
  input  norm_rsp_t          norm_rsp_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] tan_x_o,
  output logic signed [15:0] tan_y_o,
  output logic signed [15:0] tan_z_o,
  output logic               degenerate_o,
  output logic               last_of_face_o
);

  back_state_e              state_q, state_d;
  logic [1:0]               idx_q, k_q;
  logic signed [61:0]       p1_q, p2_q;
  logic [2:0][63:0]         t_q, r_q;
  logic [2:0][15:0]         tu_q, nu_q, res_q;
  logic                     tok_q, good_q;
  logic signed [31:0]       dot_q, prod_q;
  logic signed [47:0]       rp_q;

  res_t                     oq_q [OutDepth];
  logic [OutPtrW-1:0]       owp_q, orp_q;
  logic [OutCntW-1:0]       ocnt_q;
  logic                     oq_full, oq_push, oq_pop;
  res_t                     oq_w;

  logic signed [61:0]       mul_a, mul_b;
  logic signed [63:0]       tdiff, rdiff, tu64;
  logic signed [31:0]       dprod;
  logic signed [47:0]       rprod;

  always_comb begin
    mul_a = $signed(face_i.d2) * $signed(face_i.e1[idx_q]);
    mul_b = $signed(face_i.d1) * $signed(face_i.e2[idx_q]);
    tdiff = p1_q - p2_q;
    dprod = $signed(tu_q[idx_q]) * $signed(nu_q[idx_q]);
    rprod = dot_q * $signed(nu_q[idx_q]);
    tu64  = 64'($signed(tu_q[idx_q]));
    rdiff = (tu64 <<< 14) - rp_q;
  end

  assign oq_full = (ocnt_q == OutCntW'(OutDepth));
  assign oq_pop  = pop && !empty;
  assign oq_w.tx = good_q ? res_q[0] : 16'd0;
  assign oq_w.ty = good_q ? res_q[1] : 16'd0;
  assign oq_w.tz = good_q ? res_q[2] : 16'd0;
  assign oq_w.degenerate = !good_q;
  assign oq_w.last       = (k_q == 2'd2);

  always_comb begin
    state_d          = state_q;
    face_pop_o       = 1'b0;
    oq_push          = 1'b0;
    norm_req_o.start = 1'b0;
    norm_req_o.vec   = t_q;
    unique case (state_q)
      B_IDLE:   if (face_valid_i) state_d = B_TMUL;
      B_TMUL:   state_d = B_TSUB;
      B_TSUB:   state_d = (idx_q == 2'd2) ? B_TSTART : B_TMUL;
      B_TSTART: begin
        norm_req_o.start = 1'b1;
        state_d          = B_TWAIT;
      end
      B_TWAIT:  if (norm_rsp_i.done) state_d = B_NSTART;
      B_NSTART: begin
        for (int i = 0; i < 3; i++) begin
          norm_req_o.vec[i] = 64'($signed(face_i.nrm[k_q][i]));
        end
        if (tok_q) begin
          norm_req_o.start = 1'b1;
          state_d          = B_NWAIT;
        end else begin
          state_d = B_EMIT;
        end
      end
      B_NWAIT: begin
        if (norm_rsp_i.done) begin
          state_d = norm_rsp_i.ok ? B_DMUL : B_EMIT;
        end
      end
      B_DMUL:   state_d = B_DACC;
      B_DACC:   state_d = (idx_q == 2'd2) ? B_RMUL : B_DMUL;
      B_RMUL:   state_d = B_RSUB;
      B_RSUB:   state_d = (idx_q == 2'd2) ? B_RSTART : B_RMUL;
      B_RSTART: begin
        norm_req_o.vec   = r_q;
        norm_req_o.start = 1'b1;
        state_d          = B_RWAIT;
      end
      B_RWAIT:  if (norm_rsp_i.done) state_d = B_EMIT;
      B_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          if (k_q == 2'd2) begin
            face_pop_o = 1'b1;
            state_d    = B_IDLE;
          end else begin
            state_d = B_NSTART;
          end
        end
      end
      default:  state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      owp_q   <= '0;
      orp_q   <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (oq_push) owp_q <= owp_q + 1'b1;
      if (oq_pop)  orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_q + OutCntW'(oq_push) - OutCntW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[owp_q] <= oq_w;
    end
    unique case (state_q)
      B_IDLE:   idx_q <= '0;
      B_TMUL: begin
        p1_q <= mul_a;
        p2_q <= mul_b;
      end
      B_TSUB: begin
        t_q[idx_q] <= tdiff;
        idx_q      <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      B_TSTART: ;
      B_TWAIT: begin
        if (norm_rsp_i.done) begin
          tu_q  <= norm_rsp_i.res;
          tok_q <= norm_rsp_i.ok;
          k_q   <= '0;
        end
      end
      B_NSTART: begin
        if (!tok_q) good_q <= 1'b0;
      end
      B_NWAIT: begin
        if (norm_rsp_i.done) begin
          nu_q  <= norm_rsp_i.res;
          if (!norm_rsp_i.ok) good_q <= 1'b0;
          idx_q <= '0;
          dot_q <= '0;
        end
      end
      B_DMUL:   prod_q <= dprod;
      B_DACC: begin
        dot_q <= dot_q + prod_q;
        idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      B_RMUL:   rp_q <= rprod;
      B_RSUB: begin
        r_q[idx_q] <= rdiff;
        idx_q      <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      B_RSTART: ;
      B_RWAIT: begin
        if (norm_rsp_i.done) begin
          res_q  <= norm_rsp_i.res;
          good_q <= norm_rsp_i.ok;
        end
      end
      B_EMIT: begin
        if (!oq_full) k_q <= k_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign empty          = (ocnt_q == '0);
  assign tan_x_o        = oq_q[orp_q].tx;
  assign tan_y_o        = oq_q[orp_q].ty;
  assign tan_z_o        = oq_q[orp_q].tz;
  assign degenerate_o   = oq_q[orp_q].degenerate;
  assign last_of_face_o = oq_q[orp_q].last;

endmodule

### hw/rtl/triangle_tangent_generator.sv
// Top level: triangle-list vertices in, Gram-Schmidt unit tangents out, three per face.
// The first two vertices of a face are taken one per cycle while the face queue is
// not full, and held; the third closes the face into a two-deep face queue, so the
// front keeps taking vertices while the back works. The back runs up to seven passes
// of one shared normalizer per face (face tangent, then normal and projected tangent
// for each vertex), each made of a one-bit-per-cycle scaling shift, 32 square-root
// steps and 48 divide steps. Results wait in a four-beat queue; a zero-length vector
// yields a zero tangent with degenerate set.
`timescale 1ns / 1ps
module triangle_tangent_generator import ttg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] tan_x_o,
  output logic signed [15:0] tan_y_o,
  output logic signed [15:0] tan_z_o,
  output logic               degenerate_o,
  output logic               last_of_face_o
);

  logic      face_valid, face_pop;
  face_t     face;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;
  logic      tex_u_unused;

  // u does not enter the tangent
  assign tex_u_unused = ^tex_u_i;

  ttg_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_v_i,
    .norm_x_i, .norm_y_i, .norm_z_i,
    .face_valid_o (face_valid),
    .face_o       (face),
    .face_pop_i   (face_pop)
  );

  ttg_norm u_norm (
    .clk_i, .rst_ni,
    .req_i (norm_req),
    .rsp_o (norm_rsp)
  );

  ttg_back u_back (
    .clk_i, .rst_ni,
    .face_valid_i (face_valid),
    .face_i       (face),
    .face_pop_o   (face_pop),
    .norm_req_o   (norm_req),
    .norm_rsp_i   (norm_rsp),
    .empty, .pop,
    .tan_x_o, .tan_y_o, .tan_z_o, .degenerate_o, .last_of_face_o
  );

endmodule

### hw/rtl/ttg_checker.sv
// Port-level checker for the triangle tangent generator, bound to the top level.
`timescale 1ns / 1ps
`include "triangle_tangent_generator_defines.svh"
module ttg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] tan_x_o,
  input logic signed [15:0] tan_y_o,
  input logic signed [15:0] tan_z_o,
  input logic               degenerate_o,
  input logic               last_of_face_o
);

  `TTG_ASSERT_IMP(a_degen_zero, !empty && degenerate_o, tan_x_o == 16'sd0 && tan_y_o == 16'sd0 && tan_z_o == 16'sd0, "degenerate beat with nonzero tangent")
  `TTG_ASSERT_IMP(a_unit_range, !empty && !degenerate_o, tan_x_o >= -16'sd16384 && tan_x_o <= 16'sd16384 && tan_y_o >= -16'sd16384 && tan_y_o <= 16'sd16384 && tan_z_o >= -16'sd16384 && tan_z_o <= 16'sd16384, "tangent component out of unit range")
  `TTG_ASSERT_IMP(a_unit_nonzero, !empty && !degenerate_o, tan_x_o != 16'sd0 || tan_y_o != 16'sd0 || tan_z_o != 16'sd0, "valid tangent is zero")
  `TTG_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(tan_x_o) && $stable(tan_y_o) && $stable(tan_z_o) && $stable(degenerate_o) && $stable(last_of_face_o), "stalled result beat changed")

endmodule

bind triangle_tangent_generator ttg_checker u_ttg_checker (.*);

### test/testbench.sv
// Testbench for the triangle tangent generator: directed and random faces against a tangent predictor.
`timescale 1ns / 1ps
module testbench;
  import ttg_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic signed [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic signed [15:0] tx, ty, tz;
    logic               degen;
    logic               last;
  } tangent_t;

  class tangent_scoreboard;
    vertex_t  held[2];
    int       vtx_in_face;
    tangent_t pending[$];
    int       errors;

    function new();
      vtx_in_face = 0;
      errors = 0;
      held[0] = '{default: 0};
      held[1] = '{default: 0};
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else begin
          res >>= 1;
        end
        bit_w >>= 2;
      end
      return res;
    endfunction

    static function bit to_unit(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        o = '{0, 0, 0};
        return 0;
      end
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 15) + len) / (len << 1);
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    static function bit fits_31(longint x);
      return x >= -(64'sd1 <<< 30) && x <= (64'sd1 <<< 30) - 1;
    endfunction

    function void note_vertex(vertex_t v);
      vertex_t f[3];
      longint e1[3], e2[3], d1, d2, t[3], tu[3], nv[3], nu[3], r[3], res[3], dot;
      int se, sd;
      bit ok, tok, good;
      tangent_t x;
      if (vtx_in_face < 2) begin
        held[vtx_in_face] = v;
        vtx_in_face++;
        return;
      end
      vtx_in_face = 0;
      f[0] = held[0];
      f[1] = held[1];
      f[2] = v;
      e1[0] = longint'(f[1].px) - f[0].px;
      e1[1] = longint'(f[1].py) - f[0].py;
      e1[2] = longint'(f[1].pz) - f[0].pz;
      e2[0] = longint'(f[2].px) - f[0].px;
      e2[1] = longint'(f[2].py) - f[0].py;
      e2[2] = longint'(f[2].pz) - f[0].pz;
      d1 = longint'(f[1].tv) - f[0].tv;
      d2 = longint'(f[2].tv) - f[0].tv;
      se = 0;
      forever begin
        ok = 1;
        for (int i = 0; i < 3; i++)
          if (!fits_31(e1[i] >>> se) || !fits_31(e2[i] >>> se)) ok = 0;
        if (ok || se == 2) break;
        se++;
      end
      sd = 0;
      while (sd < 2 && (!fits_31(d1 >>> sd) || !fits_31(d2 >>> sd))) sd++;
      d1 = d1 >>> sd;
      d2 = d2 >>> sd;
      for (int i = 0; i < 3; i++) t[i] = d2 * (e1[i] >>> se) - d1 * (e2[i] >>> se);
      tok = to_unit(t, tu);
      for (int k = 0; k < 3; k++) begin
        good = 0;
        res = '{0, 0, 0};
        nv[0] = f[k].nx;
        nv[1] = f[k].ny;
        nv[2] = f[k].nz;
        if (tok && to_unit(nv, nu)) begin
          dot = 0;
          for (int i = 0; i < 3; i++) dot += tu[i] * nu[i];
          for (int i = 0; i < 3; i++) r[i] = tu[i] * 16384 - dot * nu[i];
          good = to_unit(r, res);
        end
        x.tx = good ? res[0][15:0] : '0;
        x.ty = good ? res[1][15:0] : '0;
        x.tz = good ? res[2][15:0] : '0;
        x.degen = !good;
        x.last = (k == 2);
        pending.insert(pending.size(), x);
      end
    endfunction

    function void check_tangent(tangent_t a);
      tangent_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.tx !== e.tx) begin $error("tan_x exp %0d got %0d", e.tx, a.tx); errors++; end
      if (a.ty !== e.ty) begin $error("tan_y exp %0d got %0d", e.ty, a.ty); errors++; end
      if (a.tz !== e.tz) begin $error("tan_z exp %0d got %0d", e.tz, a.tz); errors++; end
      if (a.degen !== e.degen) begin
        $error("degenerate exp %0b got %0b", e.degen, a.degen);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last_of_face exp %0b got %0b", e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0, push = 0, pop = 0, full, empty;
  logic signed [31:0] pos_x_i = 0, pos_y_i = 0, pos_z_i = 0, tex_u_i = 0, tex_v_i = 0;
  logic signed [15:0] norm_x_i = 0, norm_y_i = 0, norm_z_i = 0;
  logic signed [15:0] tan_x_o, tan_y_o, tan_z_o;
  logic degenerate_o, last_of_face_o;

  tangent_scoreboard sb = new();
  bit send_done = 0;
  bit in_burst = 0, out_burst = 0;

  triangle_tangent_generator dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_vertex(vertex_t v);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      @(negedge clk_i) push <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1;
    pos_x_i <= v.px; pos_y_i <= v.py; pos_z_i <= v.pz;
    tex_u_i <= v.tu; tex_v_i <= v.tv;
    norm_x_i <= v.nx; norm_y_i <= v.ny; norm_z_i <= v.nz;
    do @(posedge clk_i); while (full);
    sb.note_vertex(v);
  endtask

  function automatic vertex_t mk(int px, int py, int pz, int tv, int nx, int ny, int nz);
    vertex_t v;
    v.px = px; v.py = py; v.pz = pz;
    v.tu = $urandom; v.tv = tv;
    v.nx = nx; v.ny = ny; v.nz = nz;
    return v;
  endfunction

  function automatic vertex_t rand_vertex(bit wide);
    vertex_t v;
    if (wide) begin
      v.px = $urandom; v.py = $urandom; v.pz = $urandom;
      v.tv = $urandom;
    end else begin
      v.px = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      v.py = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      v.pz = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      v.tv = $signed($urandom_range(0, 2 ** 18)) - 2 ** 17;
    end
    v.tu = $urandom;
    if ($urandom_range(0, 19) == 0) begin
      v.nx = 0; v.ny = 0; v.nz = 0;
    end else begin
      v.nx = $urandom; v.ny = $urandom; v.nz = $urandom;
    end
    return v;
  endfunction

  initial begin
    tangent_t a;
    int gap;
    wait (rst_ni);
    forever begin
      gap = draw_gap(out_burst);
      if (gap > 0) begin
        @(negedge clk_i) pop <= 0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) pop <= 1;
      do @(posedge clk_i); while (empty);
      a.tx = tan_x_o; a.ty = tan_y_o; a.tz = tan_z_o;
      a.degen = degenerate_o; a.last = last_of_face_o;
      sb.check_tangent(a);
    end
  end

  initial begin
    vertex_t v;
    int unsigned u;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;
    // tangent along x, normal parallel to it on every vertex
    send_vertex(mk(0, 0, 0, 0, 16384, 0, 0));
    send_vertex(mk(65536, 0, 0, 0, 16384, 0, 0));
    send_vertex(mk(0, 65536, 0, 65536, -16384, 0, 0));
    // an orthogonal normal, one zero normal, extreme normal values
    send_vertex(mk(0, 0, 0, 0, 0, 0, 16384));
    send_vertex(mk(65536, 0, 0, 0, 0, 0, 0));
    send_vertex(mk(0, 65536, 0, 65536, -32768, 32767, -32768));
    // equal v everywhere: zero tangent
    send_vertex(mk(1, 2, 3, 777, 100, 200, 300));
    send_vertex(mk(-5, 9, 4, 777, 100, 200, 300));
    send_vertex(mk(7, -3, 8, 777, 100, 200, 300));
    // position and v extremes: edges and deltas need scaling
    send_vertex(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1, 2, 3));
    send_vertex(mk(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32767, 32767, 32767));
    send_vertex(mk(32'h80000000, 32'h80000000, 32'h80000000, 0, -1, 0, 0));
    send_vertex(mk(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0));
    send_vertex(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, 0, -1));
    send_vertex(mk(32'h7FFFFFFF, 1, -1, 32'h7FFFFFFF, -32768, -32768, -32768));
    // degenerate triangle: all positions equal
    send_vertex(mk(12345, 12345, 12345, 0, 3, 4, 5));
    send_vertex(mk(12345, 12345, 12345, 99, 3, 4, 5));
    send_vertex(mk(12345, 12345, 12345, 4242, 3, 4, 5));
    for (int n = 0; n < 51; n++) begin
      u = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        v = rand_vertex(u < 4);
        if (u == 9) v.tv = 1000;
        send_vertex(v);
      end
    end
    @(negedge clk_i) push <= 0;
    send_done = 1;
  end

  initial begin
    wait (send_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

### triangle_tangent_generator.f
+incdir+hw/rtl
hw/rtl/ttg_pkg.sv
hw/rtl/ttg_front.sv
hw/rtl/ttg_norm.sv
hw/rtl/ttg_back.sv
hw/rtl/triangle_tangent_generator.sv
hw/rtl/ttg_checker.sv
test/testbench.sv
